FILE: hw/rtl/gcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_pkg: shared types and tables for the counter line parser
// Character classes passed from the front to the back, the line-form token
// tables, and the result beat layout.
// ----------------------------------------------------------------------------
package gcl_pkg;

  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

  localparam logic [30:0] ACC_LIMIT = 31'h7FFF_FFFF;
  localparam logic [30:0] CPM_LIMIT = 31'd1000000;
  localparam logic [3:0]  PHASE_FAIL = 4'd15;
  localparam int          MATCH_STEPS = 3;

  typedef enum logic [1:0] {
    FORM_COLON  = 2'd0,
    FORM_DIGITS = 2'd1,
    FORM_PAIR   = 2'd2,
    FORM_NONE   = 2'd3
  } form_t;

  typedef enum logic [2:0] {
    LIT_OTHER,
    LIT_C,
    LIT_P,
    LIT_M,
    LIT_S,
    LIT_COLON,
    LIT_COMMA
  } lit_t;

  typedef enum logic [1:0] {
    TK_END,
    TK_LIT,
    TK_WS,
    TK_NUM
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t kind;
    lit_t      lit;
  } token_t;

  typedef struct packed {
    logic       last;
    logic       legal;
    logic       crlf;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    lit_t       lit;
  } char_class_t;

  typedef struct packed {
    logic        accepted;
    logic [19:0] cpm_value;
    logic        cps_present;
    logic [30:0] cps_value;
  } result_t;

  function automatic logic [3:0] form_length(input form_t form);
    logic [3:0] len;
    case (form)
      FORM_COLON:  len = 4'd6;
      FORM_DIGITS: len = 4'd1;
      FORM_PAIR:   len = 4'd14;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic token_t form_token(input form_t form, input logic [3:0] idx);
    token_t t;
    t = '{kind: TK_END, lit: LIT_OTHER};
    case (form)
      FORM_COLON: begin
        case (idx)
          4'd0: t = '{kind: TK_LIT, lit: LIT_C};
          4'd1: t = '{kind: TK_LIT, lit: LIT_P};
          4'd2: t = '{kind: TK_LIT, lit: LIT_M};
          4'd3: t = '{kind: TK_LIT, lit: LIT_COLON};
          4'd4: t = '{kind: TK_WS, lit: LIT_OTHER};
          4'd5: t = '{kind: TK_NUM, lit: LIT_OTHER};
          default: t = '{kind: TK_END, lit: LIT_OTHER};
        endcase
      end
      FORM_DIGITS: begin
        if (idx == 4'd0) t = '{kind: TK_NUM, lit: LIT_OTHER};
      end
      FORM_PAIR: begin
        case (idx)
          4'd0:  t = '{kind: TK_LIT, lit: LIT_C};
          4'd1:  t = '{kind: TK_LIT, lit: LIT_P};
          4'd2:  t = '{kind: TK_LIT, lit: LIT_S};
          4'd3:  t = '{kind: TK_LIT, lit: LIT_COMMA};
          4'd4:  t = '{kind: TK_WS, lit: LIT_OTHER};
          4'd5:  t = '{kind: TK_NUM, lit: LIT_OTHER};
          4'd6:  t = '{kind: TK_LIT, lit: LIT_COMMA};
          4'd7:  t = '{kind: TK_WS, lit: LIT_OTHER};
          4'd8:  t = '{kind: TK_LIT, lit: LIT_C};
          4'd9:  t = '{kind: TK_LIT, lit: LIT_P};
          4'd10: t = '{kind: TK_LIT, lit: LIT_M};
          4'd11: t = '{kind: TK_LIT, lit: LIT_COMMA};
          4'd12: t = '{kind: TK_WS, lit: LIT_OTHER};
          4'd13: t = '{kind: TK_NUM, lit: LIT_OTHER};
          default: t = '{kind: TK_END, lit: LIT_OTHER};
        endcase
      end
      default: t = '{kind: TK_END, lit: LIT_OTHER};
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/gcl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_front: character intake and classification
// Accepts one byte per cycle unless full, sorts it into character classes and
// holds the classified beat in a register until the middle queue takes it.
// ----------------------------------------------------------------------------
module gcl_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [7:0]           char_code,
  input  wire logic                 last_char,
  output logic                      out_valid,
  output gcl_pkg::char_class_t      out_class,
  input  wire logic                 out_full
);
  import gcl_pkg::*;

  logic        hold_valid;
  logic        hold_valid_next;
  char_class_t hold_class;
  char_class_t cls;
  logic        take;

  always_comb begin
    cls.last     = last_char;
    cls.legal    = (char_code inside {[8'h20:8'h7E]}) || char_code == 8'h0D ||
                   char_code == 8'h0A;
    cls.crlf     = char_code == 8'h0D || char_code == 8'h0A;
    cls.is_digit = char_code inside {[8'h30:8'h39]};
    cls.digit    = char_code[3:0];
    cls.is_space = char_code == 8'h20 || (char_code inside {[8'h09:8'h0D]});
    cls.is_plus  = char_code == 8'h2B;
    cls.is_minus = char_code == 8'h2D;
    case (char_code)
      8'h43:   cls.lit = LIT_C;
      8'h50:   cls.lit = LIT_P;
      8'h4D:   cls.lit = LIT_M;
      8'h53:   cls.lit = LIT_S;
      8'h3A:   cls.lit = LIT_COLON;
      8'h2C:   cls.lit = LIT_COMMA;
      default: cls.lit = LIT_OTHER;
    endcase
  end

  // The holding register frees up in the same cycle the queue takes it.
  assign full            = hold_valid && out_full;
  assign take            = push && !full;
  assign hold_valid_next = take || (hold_valid && out_full);
  assign out_valid       = hold_valid;
  assign out_class       = hold_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_class <= cls;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gcl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_fifo: queue of classified characters
// A short queue between the front and the back so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module gcl_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_valid,
  input  gcl_pkg::char_class_t      wr_data,
  output logic                      full,
  output logic                      rd_valid,
  output gcl_pkg::char_class_t      rd_data,
  input  wire logic                 rd_take
);
  import gcl_pkg::*;

  char_class_t            slots [MID_DEPTH];
  logic [MID_PTR_W-1:0]   wr_ptr;
  logic [MID_PTR_W-1:0]   rd_ptr;
  logic [MID_CNT_W-1:0]   count;
  logic                   do_wr;
  logic                   do_rd;

  assign full     = count == MID_CNT_W'(MID_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && !full;
  assign do_rd    = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + MID_PTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + MID_PTR_W'(1);
      case ({do_wr, do_rd})
        2'b10:   count <= count + MID_CNT_W'(1);
        2'b01:   count <= count - MID_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gcl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_back: line matcher and verdict queue
// Walks the selected line form one character per cycle (a closing one waits
// for queue room), sums numbers with saturation, queues one verdict per line.
// ----------------------------------------------------------------------------
module gcl_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 protocol_we,
  input  wire logic [1:0]           protocol_data,
  input  wire logic                 in_valid,
  input  gcl_pkg::char_class_t      in_class,
  output logic                      in_take,
  output logic                      empty,
  input  wire logic                 pop,
  output gcl_pkg::result_t          head
);
  import gcl_pkg::*;

  form_t       protocol;
  logic [3:0]  idx;
  logic        sign;
  logic [30:0] accum;
  logic        neg;
  logic [19:0] cpm_held;
  logic [30:0] cps_held;
  logic        cps_nonneg;
  logic        line_bad;
  logic        digit_seen;

  logic [3:0]  idx_next;
  logic        sign_next;
  logic [30:0] accum_next;
  logic        neg_next;
  logic [19:0] cpm_next;
  logic [30:0] cps_next;
  logic        cps_nonneg_next;
  logic        line_bad_next;
  logic        digit_next;

  logic [3:0]  count;
  logic [34:0] acc_sum;
  logic [30:0] acc_added;
  token_t      tok;
  logic        done;
  logic        neg_eff;
  logic        ok;
  result_t     res_next;
  logic        res_push;

  result_t     res_q [2];
  logic [1:0]  res_count;
  logic        res_full;
  logic        res_pop;
  logic        res_pos;

  assign count   = form_length(protocol);
  assign acc_sum = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} +
                   {31'd0, in_class.digit};
  assign acc_added = (acc_sum > {4'd0, ACC_LIMIT}) ? ACC_LIMIT : acc_sum[30:0];

  always_comb begin
    idx_next        = idx;
    sign_next       = sign;
    accum_next      = accum;
    neg_next        = neg;
    cpm_next        = cpm_held;
    cps_next        = cps_held;
    cps_nonneg_next = cps_nonneg;
    digit_next      = digit_seen;
    done            = 1'b0;
    neg_eff         = 1'b0;
    tok             = '{kind: TK_END, lit: LIT_OTHER};
    line_bad_next   = line_bad || !in_class.legal ||
                      (protocol == FORM_DIGITS && !in_class.is_digit && !in_class.crlf);

    // A byte can end a number and then match a literal, or skip a blank
    // token and then start on the next element, so three steps cover it.
    for (int s = 0; s < MATCH_STEPS; s++) begin
      tok = form_token(protocol, idx_next);
      if (!done) begin
        if (idx_next == PHASE_FAIL || idx_next >= count || protocol == FORM_NONE) begin
          done = 1'b1;
        end else begin
          case (tok.kind)
            TK_WS: begin
              if (in_class.is_space) done = 1'b1;
              else idx_next = idx_next + 4'd1;
            end
            TK_LIT: begin
              idx_next = (in_class.lit == tok.lit) ? idx_next + 4'd1 : PHASE_FAIL;
              done     = 1'b1;
            end
            TK_NUM: begin
              if (digit_next) begin
                if (in_class.is_digit) begin
                  accum_next = acc_added;
                  done       = 1'b1;
                end else begin
                  neg_eff = neg_next && accum_next != '0;
                  if (idx_next + 4'd1 == count) begin
                    if (neg_eff || accum_next > CPM_LIMIT) begin
                      idx_next = PHASE_FAIL;
                    end else begin
                      cpm_next = accum_next[19:0];
                      idx_next = idx_next + 4'd1;
                    end
                  end else begin
                    cps_nonneg_next = !neg_eff;
                    cps_next        = neg_eff ? '0 : accum_next;
                    idx_next        = idx_next + 4'd1;
                  end
                  accum_next = '0;
                  neg_next   = 1'b0;
                  digit_next = 1'b0;
                  sign_next  = 1'b0;
                end
              end else begin
                if (in_class.is_digit) begin
                  accum_next = acc_added;
                  digit_next = 1'b1;
                end else if (sign_next) begin
                  idx_next = PHASE_FAIL;
                end else if (in_class.is_plus || in_class.is_minus) begin
                  sign_next = 1'b1;
                  neg_next  = in_class.is_minus;
                end else if (!in_class.is_space) begin
                  idx_next = PHASE_FAIL;
                end
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
    end

    // At the end of the line a number still being read is closed.
    tok = form_token(protocol, idx_next);
    if (in_class.last && idx_next != PHASE_FAIL && idx_next < count && digit_next &&
        tok.kind == TK_NUM) begin
      neg_eff = neg_next && accum_next != '0;
      if (idx_next + 4'd1 == count) begin
        if (neg_eff || accum_next > CPM_LIMIT) begin
          idx_next = PHASE_FAIL;
        end else begin
          cpm_next = accum_next[19:0];
          idx_next = idx_next + 4'd1;
        end
      end else begin
        cps_nonneg_next = !neg_eff;
        cps_next        = neg_eff ? '0 : accum_next;
        idx_next        = idx_next + 4'd1;
      end
    end

    ok = protocol != FORM_NONE && !line_bad_next && idx_next != PHASE_FAIL &&
         idx_next == count;
    res_next.accepted    = ok;
    res_next.cpm_value   = ok ? cpm_next : '0;
    res_next.cps_present = ok && protocol == FORM_PAIR && cps_nonneg_next;
    res_next.cps_value   = res_next.cps_present ? cps_next : '0;
  end

  // Only a closing byte needs room in the verdict queue.
  assign res_full = res_count == 2'd2;
  assign in_take  = in_valid && (!in_class.last || !res_full);
  assign res_push = in_take && in_class.last;
  assign res_pop  = pop && !empty;
  assign res_pos  = res_pop ? 1'b0 : res_count[0];
  assign empty    = res_count == 2'd0;
  assign head     = res_q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol   <= FORM_COLON;
      idx        <= '0;
      sign       <= 1'b0;
      accum      <= '0;
      neg        <= 1'b0;
      cpm_held   <= '0;
      cps_held   <= '0;
      cps_nonneg <= 1'b0;
      line_bad   <= 1'b0;
      digit_seen <= 1'b0;
    end else if (protocol_we || (in_take && in_class.last)) begin
      if (protocol_we) protocol <= form_t'(protocol_data);
      idx        <= '0;
      sign       <= 1'b0;
      accum      <= '0;
      neg        <= 1'b0;
      cpm_held   <= '0;
      cps_held   <= '0;
      cps_nonneg <= 1'b0;
      line_bad   <= 1'b0;
      digit_seen <= 1'b0;
    end else if (in_take) begin
      idx        <= idx_next;
      sign       <= sign_next;
      accum      <= accum_next;
      neg        <= neg_next;
      cpm_held   <= cpm_next;
      cps_held   <= cps_next;
      cps_nonneg <= cps_nonneg_next;
      line_bad   <= line_bad_next;
      digit_seen <= digit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= '0;
    end else begin
      case ({res_push, res_pop})
        2'b10:   res_count <= res_count + 2'd1;
        2'b01:   res_count <= res_count - 2'd1;
        default: res_count <= res_count;
      endcase
    end
  end

  // A new verdict that lands in the head slot takes priority over the shift.
  always_ff @(posedge clk) begin
    if (res_push && !res_pos) begin
      res_q[0] <= res_next;
    end else if (res_pop) begin
      res_q[0] <= res_q[1];
    end
    if (res_push && res_pos) begin
      res_q[1] <= res_next;
    end
  end

  a_cps_needs_accept: assert property (@(posedge clk) disable iff (rst)
    res_push && res_next.cps_present |-> res_next.accepted)
    else $error("cps reported on a rejected line");

  a_cpm_in_range: assert property (@(posedge clk) disable iff (rst)
    res_push && res_next.accepted |-> {11'd0, res_next.cpm_value} <= CPM_LIMIT)
    else $error("accepted cpm out of range");

  a_form_none_rejects: assert property (@(posedge clk) disable iff (rst)
    res_push && protocol == FORM_NONE |-> !res_next.accepted)
    else $error("line accepted with no parser selected");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_full |-> !res_push)
    else $error("verdict written into a full queue");

  a_line_state_cleared: assert property (@(posedge clk) disable iff (rst)
    in_take && in_class.last |=> idx == '0 && !digit_seen && !line_bad)
    else $error("line state not cleared after the closing byte");

endmodule
`default_nettype wire

FILE: hw/rtl/geiger_count_line_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// geiger_count_line_parser_unit: counter text line checker and parser
// Takes a line one byte per beat and queues one verdict per line.
//
//   channel   signals                                  direction
//   -------   --------------------------------------   ---------
//   input     push/full, char_code, last_char          in
//   result    empty/pop, accepted, cpm_value,          out
//             cps_present, cps_value
//   config    protocol_we, protocol                    in
//
// One byte is taken every cycle while full is low; the matcher settles a
// byte through the token walk and the multiply-by-ten accumulate in the back.
// A verdict reaches the result queue via the front register and byte queue.
// Reset clears the queues and the line state and selects the colon form.
// Pop stalls fill the two-entry verdict queue and then the byte queue.
// ----------------------------------------------------------------------------
module geiger_count_line_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code,
  input  wire logic        last_char,
  output logic             empty,
  input  wire logic        pop,
  output logic             accepted,
  output logic [19:0]      cpm_value,
  output logic             cps_present,
  output logic [30:0]      cps_value,
  input  wire logic        protocol_we,
  input  wire logic [1:0]  protocol
);
  import gcl_pkg::*;

  logic        front_valid;
  char_class_t front_class;
  logic        mid_full;
  logic        mid_valid;
  char_class_t mid_class;
  logic        mid_take;
  result_t     head;

  gcl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (front_valid),
    .out_class (front_class),
    .out_full  (mid_full)
  );

  gcl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_data  (front_class),
    .full     (mid_full),
    .rd_valid (mid_valid),
    .rd_data  (mid_class),
    .rd_take  (mid_take)
  );

  gcl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .protocol_we   (protocol_we),
    .protocol_data (protocol),
    .in_valid      (mid_valid),
    .in_class      (mid_class),
    .in_take       (mid_take),
    .empty         (empty),
    .pop           (pop),
    .head          (head)
  );

  assign accepted    = head.accepted;
  assign cpm_value   = head.cpm_value;
  assign cps_present = head.cps_present;
  assign cps_value   = head.cps_value;

endmodule
`default_nettype wire

FILE: tb/gcl_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_line_checker: verdict predictor and scoreboard for the line parser
// Follows every byte beat taken by the parser, keeps its own copy of the
// line state and the protocol register, and compares each popped verdict,
// field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module gcl_line_checker
  import gcl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [7:0]  char_code,
  input  wire logic        last_char,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic        accepted,
  input  wire logic [19:0] cpm_value,
  input  wire logic        cps_present,
  input  wire logic [30:0] cps_value,
  input  wire logic        protocol_we,
  input  wire logic [1:0]  protocol,
  output int               mismatch_count,
  output int               verdicts_owed,
  output int               lines_passed
);

  localparam int         NO_MATCH   = PHASE_FAIL;
  localparam logic [7:0] PAT_BLANK  = " ";
  localparam logic [7:0] PAT_NUMBER = "#";

  form_t       line_form;
  int          phase_idx;
  bit          sign_taken;
  logic [30:0] num_accum;
  bit          num_negative;
  logic [20:0] cpm_held;
  logic [30:0] cps_held;
  bit          cps_nonneg;
  bit          line_bad;
  bit          digit_seen;
  result_t     verdict_q[$];

  initial begin
    mismatch_count = 0;
    verdicts_owed  = 0;
    lines_passed   = 0;
  end

  // A blank stands for any run of whitespace, a hash for one signed number.
  function automatic string form_pattern(input form_t f);
    case (f)
      FORM_COLON:  return "CPM: #";
      FORM_DIGITS: return "#";
      FORM_PAIR:   return "CPS, #, CPM, #";
      default:     return "";
    endcase
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_line_end(input logic [7:0] c);
    return c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic void clear_line();
    phase_idx    = 0;
    sign_taken   = 1'b0;
    num_accum    = '0;
    num_negative = 1'b0;
    cpm_held     = '0;
    cps_held     = '0;
    cps_nonneg   = 1'b0;
    line_bad     = 1'b0;
    digit_seen   = 1'b0;
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    logic [63:0] grown;
    grown = 64'(num_accum) * 64'd10 + 64'(c - 8'h30);
    num_accum  = (grown > 64'(ACC_LIMIT)) ? ACC_LIMIT : grown[30:0];
    digit_seen = 1'b1;
  endfunction

  // The last number of a form is the counts per minute; an earlier one is
  // the counts per second. Minus zero is treated as plain zero.
  function automatic int close_number(input int idx, input int count);
    bit neg;
    int next;
    neg  = num_negative && num_accum != '0;
    next = idx + 1;
    if (next == count) begin
      if (neg || num_accum > CPM_LIMIT) next = NO_MATCH;
      else cpm_held = num_accum[20:0];
    end else begin
      cps_nonneg = !neg;
      cps_held   = neg ? '0 : num_accum;
    end
    num_accum    = '0;
    num_negative = 1'b0;
    digit_seen   = 1'b0;
    return next;
  endfunction

  function automatic bit take_char(input logic [7:0] c, input logic lst, output result_t v);
    string      pat;
    int         count;
    int         idx;
    bit         sgn;
    bit         settled;
    bit         ok;
    logic [7:0] tok;
    pat   = form_pattern(line_form);
    count = pat.len();
    v     = '0;
    if (!((c >= 8'h20 && c <= 8'h7E) || is_line_end(c))) line_bad = 1'b1;
    if (line_form == FORM_DIGITS && !is_dec(c) && !is_line_end(c)) line_bad = 1'b1;
    idx     = phase_idx;
    sgn     = sign_taken;
    settled = 1'b0;
    while (!settled) begin
      if (idx == NO_MATCH || idx >= count) begin
        settled = 1'b1;
      end else begin
        tok = pat[idx];
        if (tok == PAT_BLANK) begin
          if (is_blank(c)) settled = 1'b1;
          else idx++;
        end else if (tok != PAT_NUMBER) begin
          idx     = (c == tok) ? idx + 1 : NO_MATCH;
          settled = 1'b1;
        end else if (digit_seen && !is_dec(c)) begin
          // The byte that ends a number is offered again to the next element.
          idx = close_number(idx, count);
          sgn = 1'b0;
        end else begin
          settled = 1'b1;
          if (is_dec(c)) begin
            add_digit(c);
          end else if (sgn) begin
            idx = NO_MATCH;
          end else if (c == "+" || c == "-") begin
            sgn          = 1'b1;
            num_negative = (c == "-");
          end else if (!is_blank(c)) begin
            idx = NO_MATCH;
          end
        end
      end
    end
    phase_idx  = idx;
    sign_taken = sgn;
    if (!lst) return 1'b0;

    if (idx != NO_MATCH && idx < count && digit_seen && pat[idx] == PAT_NUMBER)
      idx = close_number(idx, count);
    ok            = line_form != FORM_NONE && !line_bad && idx == count;
    v.accepted    = ok;
    v.cpm_value   = ok ? cpm_held[19:0] : '0;
    v.cps_present = ok && line_form == FORM_PAIR && cps_nonneg;
    v.cps_value   = v.cps_present ? cps_held : '0;
    clear_line();
    return 1'b1;
  endfunction

  function automatic void report_field(input string name, input longint want,
                                       input longint got);
    if (want != got) begin
      mismatch_count++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      line_form = FORM_COLON;
      clear_line();
      verdict_q.delete();
    end else begin
      if (protocol_we) begin
        line_form = form_t'(protocol);
        clear_line();
      end
      if (push && !full) begin
        if (take_char(char_code, last_char, want)) verdict_q.push_back(want);
      end
      if (pop && !empty) begin
        got = '{accepted: accepted, cpm_value: cpm_value,
                cps_present: cps_present, cps_value: cps_value};
        if (verdict_q.size() == 0) begin
          mismatch_count++;
          $error("verdict beat popped while no verdict was predicted");
        end else begin
          want = verdict_q.pop_front();
          report_field("accepted", want.accepted, got.accepted);
          report_field("cpm_value", want.cpm_value, got.cpm_value);
          report_field("cps_present", want.cps_present, got.cps_present);
          report_field("cps_value", want.cps_value, got.cps_value);
          if (got.accepted) lines_passed++;
        end
      end
    end
    verdicts_owed <= verdict_q.size();
  end

endmodule

FILE: tb/geiger_count_line_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geiger_count_line_parser_unit_tb: line parser testbench
// Feeds counter text lines in all four line forms, first a few hand-picked
// corner lines and then random well-formed, broken and noise lines, with
// random stalls on both the byte and the verdict side. The checker beside
// the parser predicts and compares every verdict.
// ----------------------------------------------------------------------------
module geiger_count_line_parser_unit_tb;
  import gcl_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int STIM_BEATS    = 800;
  localparam int PHASES        = 7;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  char_code;
  logic        last_char;
  logic        empty;
  logic        pop = 1'b0;
  logic        accepted;
  logic [19:0] cpm_value;
  logic        cps_present;
  logic [30:0] cps_value;
  logic        protocol_we;
  logic [1:0]  protocol;

  int          mismatch_count;
  int          verdicts_owed;
  int          lines_passed;
  int          beats_sent = 0;
  int          lines_sent = 0;
  int          quiet_cycles = 0;
  int          pop_hold = 0;
  bit          send_idle_on = 1'b0;
  bit          pop_stall_on = 1'b0;
  logic [7:0]  line_buf[$];
  form_t       plan[PHASES] = '{FORM_PAIR, FORM_COLON, FORM_DIGITS, FORM_NONE,
                                FORM_COLON, FORM_PAIR, FORM_DIGITS};

  geiger_count_line_parser_unit dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .last_char   (last_char),
    .empty       (empty),
    .pop         (pop),
    .accepted    (accepted),
    .cpm_value   (cpm_value),
    .cps_present (cps_present),
    .cps_value   (cps_value),
    .protocol_we (protocol_we),
    .protocol    (protocol)
  );

  gcl_line_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .char_code      (char_code),
    .last_char      (last_char),
    .empty          (empty),
    .pop            (pop),
    .accepted       (accepted),
    .cpm_value      (cpm_value),
    .cps_present    (cps_present),
    .cps_value      (cps_value),
    .protocol_we    (protocol_we),
    .protocol       (protocol),
    .mismatch_count (mismatch_count),
    .verdicts_owed  (verdicts_owed),
    .lines_passed   (lines_passed)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if (pop_stall_on && $urandom_range(0, 5) == 0) pop_hold = idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("geiger_count_line_parser_unit_tb: errors");
      $finish;
    end
  end

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic void add_blanks(input int most);
    int n;
    n = $urandom_range(0, most);
    repeat (n) line_buf.push_back(blank_char());
  endfunction

  // Values cluster around zero, the counts-per-minute ceiling and the
  // saturation point, with plain small counts in between.
  function automatic void add_number(input bit signed_ok);
    int roll;
    int n;
    if (signed_ok) begin
      add_blanks(1);
      roll = $urandom_range(0, 99);
      if (roll < 20) line_buf.push_back("-");
      else if (roll < 30) line_buf.push_back("+");
    end
    if ($urandom_range(0, 19) == 0) add_text("00");
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      add_text("0");
    end else if (roll < 25) begin
      add_text($sformatf("%0d", $urandom_range(999990, 1000010)));
    end else if (roll < 35) begin
      n = $urandom_range(10, 12);
      line_buf.push_back(8'($urandom_range(49, 57)));
      repeat (n - 1) line_buf.push_back(8'($urandom_range(48, 57)));
    end else if (roll < 45) begin
      add_text($sformatf("%0d", $urandom_range(0, 2147483647)));
    end else begin
      add_text($sformatf("%0d", $urandom_range(0, 9999)));
    end
  endfunction

  function automatic void add_trailer();
    int n;
    case ($urandom_range(0, 3))
      0: ;
      1: add_text("\r\n");
      2: begin
        n = $urandom_range(1, 4);
        repeat (n) line_buf.push_back(8'($urandom_range(32, 126)));
      end
      default: line_buf.push_back(8'h0A);
    endcase
  endfunction

  function automatic void build_wellformed(input form_t f);
    form_t shape;
    shape = f;
    if (f == FORM_NONE || $urandom_range(0, 6) == 0) shape = form_t'($urandom_range(0, 2));
    case (shape)
      FORM_COLON: begin
        add_text("CPM:");
        add_blanks(2);
        add_number(1'b1);
        add_trailer();
      end
      FORM_DIGITS: begin
        if ($urandom_range(0, 3) == 0) add_text("\r\n");
        add_number(1'b0);
        if ($urandom_range(0, 1) == 0) add_text("\r\n");
        if ($urandom_range(0, 3) == 0) add_number(1'b0);
      end
      default: begin
        add_text("CPS,");
        add_blanks(2);
        add_number(1'b1);
        add_text(",");
        add_blanks(2);
        add_text("CPM,");
        add_blanks(2);
        add_number(1'b1);
        add_trailer();
      end
    endcase
  endfunction

  function automatic void build_random_line(input form_t f);
    int roll;
    int pos;
    int n;
    line_buf.delete();
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      build_wellformed(f);
      // Rolls 70 to 84 damage the line: a byte swapped, the tail cut or a byte added.
      if (roll >= 70) begin
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 2))
          0:       line_buf[pos] = 8'($urandom);
          1:       line_buf = line_buf[0:pos];
          default: line_buf.insert(pos, 8'($urandom));
        endcase
      end
    end else begin
      n = $urandom_range(1, 8);
      if (roll < 92) repeat (n) line_buf.push_back(8'($urandom));
      else repeat (n) line_buf.push_back(8'($urandom_range(32, 126)));
    end
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic lst);
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    push      <= 1'b1;
    char_code <= c;
    last_char <= lst;
    do @(posedge clk); while (full);
    beats_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_beat(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
  endtask

  // Bytes with no closing beat; the next protocol write throws them away.
  task automatic send_partial();
    for (int i = 0; i < line_buf.size(); i++) send_beat(line_buf[i], 1'b0);
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    add_text(s);
    send_line();
  endtask

  task automatic send_byte_line(input logic [7:0] c);
    line_buf.delete();
    line_buf.push_back(c);
    send_line();
  endtask

  // Holds the byte side until every predicted verdict has been popped, then
  // lets a partial line settle inside the parser.
  task automatic wait_verdicts();
    push <= 1'b0;
    do @(posedge clk); while (verdicts_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_protocol(input form_t f);
    protocol_we <= 1'b1;
    protocol    <= f;
    @(posedge clk);
    protocol_we <= 1'b0;
  endtask

  initial begin
    int target;
    rst         <= 1'b1;
    push        <= 1'b0;
    char_code   <= '0;
    last_char   <= 1'b0;
    protocol_we <= 1'b0;
    protocol    <= FORM_COLON;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Corner lines, starting in the colon form that reset selects.
    send_text("CPM:-0");
    send_text("CPM:-");
    send_byte_line(8'h00);
    wait_verdicts();
    write_protocol(FORM_DIGITS);
    send_text("7a");
    wait_verdicts();
    write_protocol(FORM_NONE);
    send_byte_line(8'hFF);
    line_buf.delete();
    add_text("C");
    send_partial();
    wait_verdicts();
    write_protocol(FORM_PAIR);
    send_text("CPS,-5,CPM,0");

    for (int p = 0; p < PHASES; p++) begin
      wait_verdicts();
      write_protocol(plan[p]);
      send_idle_on = (p % 3) != 2;
      pop_stall_on = (p % 3) != 1;
      target = beats_sent + STIM_BEATS / PHASES;
      while (beats_sent < target) begin
        build_random_line(plan[p]);
        send_line();
        if ($urandom_range(0, 29) == 0) wait_verdicts();
      end
      if ($urandom_range(0, 1) == 0) begin
        build_random_line(plan[p]);
        send_partial();
      end
    end

    wait_verdicts();
    @(negedge clk);
    $display("Sent %0d byte beats forming %0d lines over all four protocol settings;",
             beats_sent, lines_sent);
    $display("%0d of those lines were parsed and passed the checks.", lines_passed);
    if (mismatch_count == 0 && verdicts_owed == 0) begin
      $display("geiger_count_line_parser_unit_tb: clean");
    end else begin
      $display("geiger_count_line_parser_unit_tb: errors");
    end
    $finish;
  end

endmodule
